/* rtl/dmht_pkg.sv */
// Shared types and constants for the direct-mapped hash table.
// Holds the job record passed from the key front end to the table back end.
// No dependencies.
package dmht_pkg;

  localparam int HASH_W        = 64;
  localparam int KEY_W         = 64;
  localparam int LEN_W         = 4;
  localparam int VALUE_W       = 32;
  localparam int CHAR_W        = 8;
  localparam int MAX_KEY_CHARS = 8;

  localparam int JOB_DEPTH = 2;

  localparam logic [HASH_W-1:0]  HASH_SEED  = 64'd5381;
  localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_GET    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  localparam logic [2:0] ST_INSERTED    = 3'd0;
  localparam logic [2:0] ST_COLLISION   = 3'd1;
  localparam logic [2:0] ST_FOUND       = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [2:0] ST_REMOVED     = 3'd4;
  localparam logic [2:0] ST_REMOVE_MISS = 3'd5;
  localparam logic [2:0] ST_TOO_LONG    = 3'd6;

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [KEY_W-1:0]   key;
    logic [LEN_W-1:0]   len;
    logic               overflow;
    logic [1:0]         mode;
    logic [VALUE_W-1:0] value;
  } job_t;

endpackage

/* rtl/dmht_front.sv */
// Key front end: hashes and buffers one key character per beat.
// Emits a complete job on the last character. Uses dmht_pkg.
module dmht_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           mode,
  input  logic [7:0]           key_char,
  input  logic                 key_last,
  input  logic [31:0]          insert_value,
  input  logic                 q_full,
  input  logic                 clearing,
  output logic                 job_push,
  output dmht_pkg::job_t       job
);
  import dmht_pkg::*;

  logic [HASH_W-1:0] hash;
  logic [KEY_W-1:0]  kbuf;
  logic [LEN_W-1:0]  klen;
  logic              kovf;

  logic [HASH_W-1:0] hash_next;
  logic [KEY_W-1:0]  kbuf_next;
  logic [LEN_W-1:0]  klen_next;
  logic              kovf_next;
  logic              accept;

  assign full   = q_full | clearing;
  assign accept = push & ~full;

  always_comb begin
    hash_next = (hash << 5) + hash + HASH_W'(key_char);
    kbuf_next = kbuf;
    klen_next = klen;
    kovf_next = kovf;
    if (klen < LEN_W'(MAX_KEY_CHARS)) begin
      kbuf_next = kbuf | (KEY_W'(key_char) << {klen[2:0], 3'b000});
      klen_next = klen + LEN_W'(1);
    end else begin
      kovf_next = 1'b1;
    end
  end

  assign job_push     = accept & key_last;
  assign job.hash     = hash_next;
  assign job.key      = kbuf_next;
  assign job.len      = klen_next;
  assign job.overflow = kovf_next;
  assign job.mode     = mode;
  assign job.value    = insert_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= HASH_SEED;
      kbuf <= '0;
      klen <= '0;
      kovf <= 1'b0;
    end else if (accept) begin
      if (key_last) begin
        hash <= HASH_SEED;
        kbuf <= '0;
        klen <= '0;
        kovf <= 1'b0;
      end else begin
        hash <= hash_next;
        kbuf <= kbuf_next;
        klen <= klen_next;
        kovf <= kovf_next;
      end
    end
  end

endmodule

/* rtl/dmht_job_fifo.sv */
// Short job queue between key front end and table back end.
// Uses dmht_pkg.
module dmht_job_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  dmht_pkg::job_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output dmht_pkg::job_t rd_data,
  output logic           valid
);
  import dmht_pkg::*;

  localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOB_DEPTH + 1);

  job_t             slots [JOB_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = count == CNT_W'(JOB_DEPTH);
  assign valid   = count != '0;
  assign rd_data = slots[rd_ptr];
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/dmht_back.sv */
// Table back end: hash modulo unit, slot memory, op execution, result register.
// Clears the slot memory after reset. Uses dmht_pkg.
module dmht_back #(
  parameter int TABLE_SLOTS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  dmht_pkg::job_t      job_in,
  output logic                job_pop,
  output logic                clearing,
  output logic                empty,
  input  logic                pop,
  output logic [2:0]          status,
  output logic signed [31:0]  read_value,
  output logic [3:0]          slot_index
);
  import dmht_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_SLOTS);
  localparam int FOLD_W = 18 + IDX_W;
  localparam int PROD_W = 2 * FOLD_W;
  localparam logic [IDX_W:0]   SLOTS_EXT = (IDX_W + 1)'(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
  // weights of the upper 16-bit hash chunks, 2^(16k) mod TABLE_SLOTS
  localparam logic [IDX_W-1:0] W1 = IDX_W'((64'd1 << 16) % TABLE_SLOTS);
  localparam logic [IDX_W-1:0] W2 = IDX_W'((64'd1 << 32) % TABLE_SLOTS);
  localparam logic [IDX_W-1:0] W3 = IDX_W'((64'd1 << 48) % TABLE_SLOTS);
  localparam logic [FOLD_W-1:0] RECIP = FOLD_W'((64'd1 << FOLD_W) / TABLE_SLOTS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FOLD,
    S_RECIP,
    S_MOD,
    S_LOOKUP,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [LEN_W-1:0]   len;
    logic [VALUE_W-1:0] value;
  } entry_t;

  entry_t mem [TABLE_SLOTS];
  entry_t rd_entry;

  state_t             state;
  job_t               job;
  logic [FOLD_W-1:0]  fold;
  logic [FOLD_W-1:0]  quot;
  logic [IDX_W-1:0]   rem;
  logic [IDX_W-1:0]   clr_addr;

  logic               out_valid;
  logic [2:0]         out_status;
  logic [VALUE_W-1:0] out_value;
  logic [3:0]         out_slot;

  logic [FOLD_W-1:0]  fold_next;
  logic [PROD_W-1:0]  recip_prod;
  logic [IDX_W:0]     rem_raw;
  logic [IDX_W-1:0]   rem_next;
  logic               out_free;
  logic               match;
  logic [2:0]         res_status;
  logic [VALUE_W-1:0] res_value;
  logic               exec_we;
  entry_t             exec_wdata;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic               mem_re;

  // hash mod TABLE_SLOTS: fold 16-bit chunks by their weights, then a reciprocal
  // quotient that is at most one low, fixed by one compare-subtract
  assign fold_next = FOLD_W'(job.hash[15:0])
                   + FOLD_W'(job.hash[31:16]) * FOLD_W'(W1)
                   + FOLD_W'(job.hash[47:32]) * FOLD_W'(W2)
                   + FOLD_W'(job.hash[63:48]) * FOLD_W'(W3);

  assign recip_prod = PROD_W'(fold) * PROD_W'(RECIP);

  assign rem_raw  = fold[IDX_W:0] - quot[IDX_W:0] * SLOTS_EXT;
  assign rem_next = (rem_raw >= SLOTS_EXT) ? IDX_W'(rem_raw - SLOTS_EXT)
                                           : rem_raw[IDX_W-1:0];

  assign out_free = ~out_valid | pop;
  assign match    = rd_entry.valid && rd_entry.key == job.key && rd_entry.len == job.len;

  always_comb begin
    res_status = ST_NOT_FOUND;
    res_value  = MISS_VALUE;
    exec_we    = 1'b0;
    exec_wdata = rd_entry;
    if (job.overflow) begin
      res_status = ST_TOO_LONG;
    end else begin
      case (job.mode)
        MODE_INSERT: begin
          if (rd_entry.valid) begin
            res_status = ST_COLLISION;
          end else begin
            res_status       = ST_INSERTED;
            exec_we          = 1'b1;
            exec_wdata.valid = 1'b1;
            exec_wdata.key   = job.key;
            exec_wdata.len   = job.len;
            exec_wdata.value = job.value;
          end
        end
        MODE_REMOVE: begin
          if (match) begin
            res_status       = ST_REMOVED;
            exec_we          = 1'b1;
            exec_wdata.valid = 1'b0;
          end else begin
            res_status = ST_REMOVE_MISS;
          end
        end
        MODE_GET, MODE_SPARE: begin
          if (match) begin
            res_status = ST_FOUND;
            res_value  = rd_entry.value;
          end
        end
        default: begin
          res_status = ST_NOT_FOUND;
        end
      endcase
    end
  end

  assign mem_we    = (state == S_CLEAR) || (state == S_EXEC && out_free && exec_we);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : rem;
  assign mem_wdata = (state == S_CLEAR) ? entry_t'('0) : exec_wdata;
  assign mem_re    = state == S_LOOKUP;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_entry <= mem[rem];
    end
  end

  assign job_pop  = (state == S_IDLE) && job_valid;
  assign clearing = state == S_CLEAR;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EXEC && out_free) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (job_valid) begin
            job   <= job_in;
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          fold  <= fold_next;
          state <= S_RECIP;
        end
        S_RECIP: begin
          quot  <= recip_prod[PROD_W-1:FOLD_W];
          state <= S_MOD;
        end
        S_MOD: begin
          rem   <= rem_next;
          state <= S_LOOKUP;
        end
        S_LOOKUP: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            out_status <= res_status;
            out_value  <= res_value;
            out_slot   <= 4'(rem);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign empty      = ~out_valid;
  assign status     = out_status;
  assign read_value = out_value;
  assign slot_index = out_slot;

endmodule

/* rtl/direct_mapped_hash_table_top.sv */
// Direct-mapped djb2 key/value table, top level. Uses dmht_pkg, dmht_front,
// dmht_job_fifo and dmht_back.
// Key characters are taken one per cycle while full is low; a completed key is queued for the back end.
// Each op steps the back end through queue pop, hash fold, reciprocal step, remainder,
// slot read and execute (execute waits while the previous result is unpopped); one op at a time.
// After reset the slot memory is swept with full held high.
module direct_mapped_hash_table_top #(
  parameter int TABLE_SLOTS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         mode,
  input  logic [7:0]         key_char,
  input  logic               key_last,
  input  logic signed [31:0] insert_value,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         status,
  output logic signed [31:0] read_value,
  output logic [3:0]         slot_index
);
  import dmht_pkg::*;

  job_t job_w;
  job_t job_r;
  logic job_push;
  logic q_full;
  logic q_valid;
  logic job_pop;
  logic clearing;

  dmht_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .mode         (mode),
    .key_char     (key_char),
    .key_last     (key_last),
    .insert_value (insert_value),
    .q_full       (q_full),
    .clearing     (clearing),
    .job_push     (job_push),
    .job          (job_w)
  );

  dmht_job_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_w),
    .full    (q_full),
    .rd_en   (job_pop),
    .rd_data (job_r),
    .valid   (q_valid)
  );

  dmht_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (q_valid),
    .job_in     (job_r),
    .job_pop    (job_pop),
    .clearing   (clearing),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .read_value (read_value),
    .slot_index (slot_index)
  );

endmodule

/* tb/dmht_result_checker.sv */
// Scoreboard for direct_mapped_hash_table_top: folds each accepted key beat into
// its own djb2 table model and checks every result beat in order.
// Depends on dmht_pkg.
module dmht_result_checker
  import dmht_pkg::*;
#(
  parameter int TABLE_SLOTS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic [1:0]         mode,
  input  logic [7:0]         key_char,
  input  logic               key_last,
  input  logic signed [31:0] insert_value,
  input  logic               empty,
  input  logic               pop,
  input  logic [2:0]         status,
  input  logic signed [31:0] read_value,
  input  logic [3:0]         slot_index,
  output int                 fail_count,
  output int                 pending_results
);

  typedef struct packed {
    logic [2:0]         status;
    logic [VALUE_W-1:0] value;
    logic [3:0]         slot;
  } table_outcome_t;

  table_outcome_t outcome_q[$];

  logic [HASH_W-1:0]  key_hash;
  logic [KEY_W-1:0]   key_buf;
  logic [LEN_W-1:0]   key_len;
  logic               key_long;

  logic               slot_valid   [TABLE_SLOTS];
  logic [KEY_W-1:0]   slot_key     [TABLE_SLOTS];
  logic [LEN_W-1:0]   slot_key_len [TABLE_SLOTS];
  logic [VALUE_W-1:0] slot_value   [TABLE_SLOTS];

  always @(posedge clk) begin : track
    table_outcome_t want;
    table_outcome_t got;
    int             slot;
    logic           hit;
    if (rst) begin
      key_hash   = HASH_SEED;
      key_buf    = '0;
      key_len    = '0;
      key_long   = 1'b0;
      fail_count = 0;
      foreach (slot_valid[i]) begin
        slot_valid[i]   = 1'b0;
        slot_key[i]     = '0;
        slot_key_len[i] = '0;
        slot_value[i]   = '0;
      end
      outcome_q.delete();
    end else begin
      if (pop && !empty) begin
        got.status = status;
        got.value  = read_value;
        got.slot   = slot_index;
        if (outcome_q.size() == 0) begin
          $error("result beat with nothing expected: status %0d slot %0d", status, slot_index);
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.value !== want.value) begin
            $error("read_value: expected %0d, got %0d", $signed(want.value),
                   $signed(got.value));
            fail_count++;
          end
          if (got.slot !== want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot, got.slot);
            fail_count++;
          end
        end
      end
      if (push && !full) begin
        key_hash = (key_hash << 5) + key_hash + HASH_W'(key_char);
        if (key_len < MAX_KEY_CHARS) begin
          key_buf[8*key_len +: 8] = key_char;
          key_len = key_len + 1'b1;
        end else begin
          key_long = 1'b1;
        end
        if (key_last) begin
          slot = int'(key_hash % HASH_W'(TABLE_SLOTS));
          hit  = slot_valid[slot] && slot_key[slot] == key_buf && slot_key_len[slot] == key_len;
          want.value = MISS_VALUE;
          want.slot  = slot[3:0];
          if (key_long) begin
            want.status = ST_TOO_LONG;
          end else if (mode == MODE_INSERT) begin
            if (slot_valid[slot]) begin
              want.status = ST_COLLISION;
            end else begin
              slot_valid[slot]   = 1'b1;
              slot_key[slot]     = key_buf;
              slot_key_len[slot] = key_len;
              slot_value[slot]   = insert_value;
              want.status        = ST_INSERTED;
            end
          end else if (mode == MODE_REMOVE) begin
            if (hit) begin
              slot_valid[slot] = 1'b0;
              want.status      = ST_REMOVED;
            end else begin
              want.status = ST_REMOVE_MISS;
            end
          end else begin
            // spare mode reads like get
            if (hit) begin
              want.value  = slot_value[slot];
              want.status = ST_FOUND;
            end else begin
              want.status = ST_NOT_FOUND;
            end
          end
          outcome_q.push_back(want);
          key_hash = HASH_SEED;
          key_buf  = '0;
          key_len  = '0;
          key_long = 1'b0;
        end
      end
    end
    pending_results = outcome_q.size();
  end

endmodule

/* tb/direct_mapped_hash_table_top_tb.sv */
// Testbench top for direct_mapped_hash_table_top: drives key beats and result pops
// with random idling, and gives the verdict from dmht_result_checker.
// Depends on dmht_pkg, dmht_result_checker and the RTL.
module direct_mapped_hash_table_top_tb;
  import dmht_pkg::*;

  localparam int ITEM_TARGET = 1350;
  localparam int QUIET_FROM  = 1150;
  localparam int DRAIN_AT    = 700;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 250;
  localparam int STALL_LIMIT = 2000;
  localparam int POOL_KEYS   = 16;

  logic               clk = 1'b0;
  logic               rst;
  logic               push;
  logic               full;
  logic [1:0]         mode;
  logic [7:0]         key_char;
  logic               key_last;
  logic signed [31:0] insert_value;
  logic               empty;
  logic               pop;
  logic [2:0]         status;
  logic signed [31:0] read_value;
  logic [3:0]         slot_index;

  int fail_count;
  int pending_results;
  int items_sent = 0;
  int stalled_cycles = 0;
  bit quiet = 1'b0;
  bit long_hold_done = 1'b0;

  logic [95:0] pool_text [POOL_KEYS];
  int          pool_len  [POOL_KEYS];

  always #2 clk = ~clk;

  direct_mapped_hash_table_top uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .mode(mode), .key_char(key_char),
    .key_last(key_last), .insert_value(insert_value), .empty(empty), .pop(pop),
    .status(status), .read_value(read_value), .slot_index(slot_index)
  );

  dmht_result_checker result_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .mode(mode), .key_char(key_char),
    .key_last(key_last), .insert_value(insert_value), .empty(empty), .pop(pop),
    .status(status), .read_value(read_value), .slot_index(slot_index),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  always @(posedge clk) begin
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("direct_mapped_hash_table_top regression: fail");
      $finish;
    end else if (rst || (push && !full) || (pop && !empty)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  function automatic logic [95:0] random_text(input int len);
    logic [95:0] t;
    t = '0;
    for (int i = 0; i < len; i++) t[8*i +: 8] = 8'($urandom_range(1, 255));
    return t;
  endfunction

  task automatic drive_char(input logic [1:0] op, input logic [7:0] c, input logic last,
                            input logic [31:0] val);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 9);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push         <= 1'b1;
    mode         <= op;
    key_char     <= c;
    key_last     <= last;
    insert_value <= val;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic send_key(input logic [1:0] op, input logic [95:0] text, input int len,
                          input logic [31:0] val);
    int i;
    for (i = 0; i < len - 1; i++) drive_char(2'($urandom), text[8*i +: 8], 1'b0, $urandom);
    drive_char(op, text[8*(len-1) +: 8], 1'b1, val);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // result side: random pop bursts, one long hold-off so the input backs up
  initial begin : result_drain
    int gap;
    pop = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!long_hold_done && items_sent >= HOLD_AT) begin
        long_hold_done = 1'b1;
        pop <= 1'b0;
        gap = HOLD_CYCLES;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        gap = $urandom_range(1, 9);
      end else begin
        pop <= 1'b1;
        gap = $urandom_range(1, 12);
      end
      repeat (gap - 1) @(negedge clk);
    end
  end

  initial begin : key_source
    int       len;
    int       p;
    int       pick;
    int       roll;
    bit       drain_done;
    logic [1:0] op;
    rst          = 1'b1;
    push         = 1'b0;
    mode         = MODE_INSERT;
    key_char     = 8'h01;
    key_last     = 1'b0;
    insert_value = '0;
    drain_done   = 1'b0;
    for (int i = 0; i < POOL_KEYS; i++) begin
      pool_len[i]  = $urandom_range(1, 8);
      pool_text[i] = random_text(pool_len[i]);
    end
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // one-char key: insert, repeat insert, get, spare mode, remove twice, get on empty
    send_key(MODE_INSERT, 96'h01, 1, 32'h7FFF_FFFF);
    send_key(MODE_INSERT, 96'h01, 1, 32'h0000_0000);
    send_key(MODE_GET,    96'h01, 1, 32'h0);
    send_key(MODE_SPARE,  96'h01, 1, 32'h0);
    send_key(MODE_REMOVE, 96'h01, 1, 32'h0);
    send_key(MODE_REMOVE, 96'h01, 1, 32'h0);
    send_key(MODE_GET,    96'h01, 1, 32'h0);
    // zero character, full-length key, one char too many
    send_key(MODE_INSERT, 96'h00, 1, 32'h8000_0000);
    send_key(MODE_INSERT, {32'h0, {8{8'hFF}}}, 8, 32'h0);
    send_key(MODE_GET, random_text(9), 9, $urandom);

    while (items_sent < ITEM_TARGET) begin
      if (!drain_done && items_sent >= DRAIN_AT) begin
        drain_done = 1'b1;
        wait_drained();
      end
      quiet = items_sent >= QUIET_FROM;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        len = $urandom_range(9, 12);
        send_key(2'($urandom), random_text(len), len, $urandom);
      end else if (pick < 12) begin
        len = $urandom_range(1, 8);
        send_key(2'($urandom), random_text(len), len, $urandom);
      end else begin
        p = $urandom_range(0, POOL_KEYS - 1);
        if ($urandom_range(0, 19) == 0) begin
          pool_len[p]  = $urandom_range(1, 8);
          pool_text[p] = random_text(pool_len[p]);
        end
        roll = $urandom_range(0, 99);
        if (roll < 40)      op = MODE_INSERT;
        else if (roll < 70) op = MODE_GET;
        else if (roll < 95) op = MODE_REMOVE;
        else                op = MODE_SPARE;
        send_key(op, pool_text[p], pool_len[p], $urandom);
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("direct_mapped_hash_table_top regression: pass");
    end else begin
      $display("direct_mapped_hash_table_top regression: fail");
    end
    $finish;
  end

endmodule
